/* rtl/core/pts_pkg.sv */
// pts_pkg: types and constants shared by the periodic timer slot table
// depends on nothing; used by pts_cell and periodic_timer_slot_table
package pts_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int MAX_EVENTS = 32;
  localparam int STEP_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int EVT_W      = $clog2(MAX_EVENTS + 1);

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CREATE = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RK_CREATED  = 3'd0,
    RK_NOFREE   = 3'd1,
    RK_DELETED  = 3'd2,
    RK_RANGE    = 3'd3,
    RK_FIRED    = 3'd4,
    RK_FINISHED = 3'd5,
    RK_NONE     = 3'd6
  } result_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic               active;
    logic [30:0]        period;
    logic signed [31:0] limit;
    logic [31:0]        fired;
    logic [47:0]        start;
  } rec_t;

  typedef struct packed {
    result_kind_e kind;
    logic [5:0]   slot;
    logic [31:0]  cnt;
  } res_t;

endpackage

/* rtl/core/pts_cell.sv */
// pts_cell: one timer slot record in the rotating ring
// depends on pts_pkg for the record type
module pts_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  pts_pkg::rec_t rec_i,
  output pts_pkg::rec_t rec_o
);

  logic          active_q, active_d;
  pts_pkg::rec_t data_q, data_d;

  always_comb begin
    active_d = shift_i ? rec_i.active : active_q;
    data_d   = shift_i ? rec_i : data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // payload needs no reset, it is only read behind the active bit
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    rec_o        = data_q;
    rec_o.active = active_q;
  end

endmodule

/* rtl/core/periodic_timer_slot_table.sv */
// periodic timer slot table: timer records rotate through a ring of cells
// every transaction runs to its final result before the next one is accepted:
// accept in idle, scan the ring in NUM_TIMERS steps, deliver the last result in done
// output stalls can hold both the scan and the done state
// one transaction at a time; results before the last leave the block during the scan
// reset (asynchronous, active low) frees all slots and empties the output
module periodic_timer_slot_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [47:0] now_i,
  input  logic [30:0] period_i,
  input  logic signed [31:0] repeat_limit_i,
  input  logic [47:0] start_time_i,
  input  logic [7:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [5:0]  timer_slot_o,
  output logic [31:0] fire_count_o,
  output logic        last_o
);

  localparam int N = pts_pkg::NUM_TIMERS;

  pts_pkg::state_e state_q, state_d;
  logic [pts_pkg::STEP_W-1:0] step_q, step_d;
  logic [pts_pkg::EVT_W-1:0]  nev_q, nev_d;
  logic        pend_v_q, pend_v_d;
  pts_pkg::res_t pend_q, pend_d;
  pts_pkg::kind_e kind_q;
  logic [47:0] now_q, start_q;
  logic [30:0] period_q;
  logic signed [31:0] limit_q;
  logic [7:0]  slot_q;

  logic        out_valid_q, out_valid_d;
  pts_pkg::res_t out_q, out_d;
  logic        last_q, last_d;

  pts_pkg::rec_t ring [N];
  pts_pkg::rec_t head_next, h;
  logic shift, adv, out_free, in_acc;
  logic new_v, emit_mid;
  pts_pkg::res_t new_res;
  logic [48:0] due_sum;
  logic [47:0] st_eff;

  // ---------------- ring of cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    pts_pkg::rec_t cin;
    if (k == N - 1) begin : g_tail
      assign cin = head_next;
    end else begin : g_mid
      assign cin = ring[k+1];
    end
    pts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  (cin),
      .rec_o  (ring[k])
    );
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != pts_pkg::ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;

  // ---------------- head processing
  assign h = ring[0];
  assign due_sum = {1'b0, h.start} + {18'd0, h.period};
  assign st_eff = (start_q == 48'd0 || start_q < now_q) ? now_q : start_q;

  always_comb begin
    head_next = h;
    new_v     = 1'b0;
    new_res   = '{kind: pts_pkg::RK_NONE, slot: 6'(step_q), cnt: 32'd0};
    case (kind_q)
      pts_pkg::KIND_TICK: begin
        if (h.active && due_sum <= {1'b0, now_q} &&
            nev_q < pts_pkg::EVT_W'(pts_pkg::MAX_EVENTS)) begin
          new_v = 1'b1;
          if (h.limit == -32'sd1 ||
              (h.limit > 32'sd0 && h.fired < $unsigned(h.limit))) begin
            head_next.fired = (h.fired == 32'hFFFF_FFFF) ? h.fired : h.fired + 32'd1;
            head_next.start = now_q;
            new_res.kind    = pts_pkg::RK_FIRED;
            new_res.cnt     = head_next.fired;
          end else begin
            head_next.active = 1'b0;
            new_res.kind     = pts_pkg::RK_FINISHED;
            new_res.cnt      = h.fired;
          end
        end
      end
      pts_pkg::KIND_CREATE: begin
        // first free slot only; a pending result marks the slot as taken
        if (!h.active && !pend_v_q) begin
          new_v        = 1'b1;
          new_res.kind = pts_pkg::RK_CREATED;
          head_next    = '{active: 1'b1, period: period_q, limit: limit_q,
                           fired: 32'd0, start: st_eff};
        end
      end
      pts_pkg::KIND_DELETE: begin
        if (slot_q == 8'(step_q)) begin
          head_next.active = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // an earlier result can leave only once the next one is known
  assign emit_mid = new_v && pend_v_q;
  assign adv      = !emit_mid || out_free;
  assign shift    = (state_q == pts_pkg::ST_SCAN) && adv;

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pts_pkg::ST_IDLE: if (in_acc) state_d = pts_pkg::ST_SCAN;
      pts_pkg::ST_SCAN: begin
        if (adv && step_q == pts_pkg::STEP_W'(N - 1)) state_d = pts_pkg::ST_DONE;
      end
      pts_pkg::ST_DONE: if (out_free) state_d = pts_pkg::ST_IDLE;
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath and outputs
  always_comb begin
    step_d      = step_q;
    nev_d       = nev_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    last_d      = last_q;
    case (state_q)
      pts_pkg::ST_IDLE: begin
        step_d   = '0;
        nev_d    = '0;
        pend_v_d = 1'b0;
        if (in_acc && kind_i == pts_pkg::KIND_DELETE) begin
          pend_v_d    = 1'b1;
          pend_d.kind = (slot_i >= 8'(N)) ? pts_pkg::RK_RANGE : pts_pkg::RK_DELETED;
          pend_d.slot = slot_i[5:0];
          pend_d.cnt  = 32'd0;
        end
      end
      pts_pkg::ST_SCAN: begin
        if (adv) begin
          step_d = step_q + 1'b1;
          if (new_v) begin
            pend_v_d = 1'b1;
            pend_d   = new_res;
            if (kind_q == pts_pkg::KIND_TICK) nev_d = nev_q + 1'b1;
          end
          if (emit_mid) begin
            out_valid_d = 1'b1;
            out_d       = pend_q;
            last_d      = 1'b0;
          end
        end
      end
      pts_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          pend_v_d    = 1'b0;
          if (pend_v_q) begin
            out_d = pend_q;
          end else begin
            out_d = '{kind: (kind_q == pts_pkg::KIND_CREATE) ? pts_pkg::RK_NOFREE
                                                             : pts_pkg::RK_NONE,
                      slot: 6'd0, cnt: 32'd0};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pts_pkg::ST_IDLE;
      step_q      <= '0;
      nev_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      nev_q       <= nev_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
    if (in_acc) begin
      kind_q   <= pts_pkg::kind_e'(kind_i);
      now_q    <= now_i;
      period_q <= period_i;
      limit_q  <= repeat_limit_i;
      start_q  <= start_time_i;
      slot_q   <= slot_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_q.kind;
  assign timer_slot_o  = out_q.slot;
  assign fire_count_o  = out_q.cnt;
  assign last_o        = last_q;

  // ---------------- assertions
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_IDLE) |-> !pend_v_q)
    else $error("pending result left over in idle");

  a_event_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nev_q <= pts_pkg::EVT_W'(pts_pkg::MAX_EVENTS))
    else $error("event count beyond limit");

  a_done_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_DONE && out_free) |=> (state_q == pts_pkg::ST_IDLE && out_valid_q))
    else $error("final result not delivered");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_SCAN && adv && step_q == pts_pkg::STEP_W'(N - 1))
      |=> state_q == pts_pkg::ST_DONE)
    else $error("scan did not end after a full ring pass");

endmodule
